// File: sv/nfsd_pkg.sv
`default_nettype none
package nfsd_pkg;

    localparam int FrameLen   = 137;
    localparam int SumFirst   = 2;
    localparam int CheckPos   = 135;
    localparam int FieldCount = 40;

    localparam logic [7:0] Sync0 = 8'hAA;
    localparam logic [7:0] Sync1 = 8'h55;
    localparam logic [7:0] Sync2 = 8'h01;
    localparam logic [7:0] Sync3 = 8'h58;

    typedef struct packed {
        logic [7:0] offset;
        logic [3:0] size;
        logic       is_signed;
    } t_field_desc;

    function automatic t_field_desc field_desc(input logic [5:0] idx);
        t_field_desc d;
        case (idx)
            6'd0:  d = '{8'd6,   4'd2, 1'b0};
            6'd1:  d = '{8'd8,   4'd2, 1'b1};
            6'd2:  d = '{8'd10,  4'd2, 1'b1};
            6'd3:  d = '{8'd12,  4'd4, 1'b1};
            6'd4:  d = '{8'd16,  4'd4, 1'b1};
            6'd5:  d = '{8'd20,  4'd4, 1'b1};
            6'd6:  d = '{8'd24,  4'd4, 1'b1};
            6'd7:  d = '{8'd28,  4'd4, 1'b1};
            6'd8:  d = '{8'd32,  4'd4, 1'b1};
            6'd9:  d = '{8'd36,  4'd2, 1'b1};
            6'd10: d = '{8'd38,  4'd2, 1'b1};
            6'd11: d = '{8'd40,  4'd2, 1'b1};
            6'd12: d = '{8'd42,  4'd2, 1'b0};
            6'd13: d = '{8'd44,  4'd2, 1'b0};
            6'd14: d = '{8'd46,  4'd2, 1'b1};
            6'd15: d = '{8'd48,  4'd8, 1'b1};
            6'd16: d = '{8'd56,  4'd8, 1'b1};
            6'd17: d = '{8'd64,  4'd4, 1'b1};
            6'd18: d = '{8'd68,  4'd4, 1'b1};
            6'd19: d = '{8'd72,  4'd4, 1'b1};
            6'd20: d = '{8'd76,  4'd4, 1'b1};
            6'd21: d = '{8'd80,  4'd8, 1'b1};
            6'd22: d = '{8'd88,  4'd8, 1'b1};
            6'd23: d = '{8'd96,  4'd4, 1'b1};
            6'd24: d = '{8'd100, 4'd4, 1'b1};
            6'd25: d = '{8'd104, 4'd2, 1'b1};
            6'd26: d = '{8'd106, 4'd4, 1'b1};
            6'd27: d = '{8'd110, 4'd4, 1'b0};
            6'd28: d = '{8'd114, 4'd1, 1'b0};
            6'd29: d = '{8'd115, 4'd1, 1'b0};
            6'd30: d = '{8'd116, 4'd1, 1'b0};
            6'd31: d = '{8'd117, 4'd2, 1'b0};
            6'd32: d = '{8'd119, 4'd1, 1'b0};
            6'd33: d = '{8'd120, 4'd2, 1'b0};
            6'd34: d = '{8'd122, 4'd2, 1'b1};
            6'd35: d = '{8'd124, 4'd2, 1'b1};
            6'd36: d = '{8'd126, 4'd2, 1'b1};
            6'd37: d = '{8'd128, 4'd2, 1'b0};
            6'd38: d = '{8'd130, 4'd4, 1'b0};
            6'd39: d = '{8'd134, 4'd1, 1'b0};
            default: d = '{8'd0, 4'd1, 1'b0};
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// File: sv/nav_frame_sync_and_field_decoder.sv
`default_nettype none
// Operation: after the last byte of a matched frame is written, the sync and check reads and
// the compare run; each field is then read byte by byte through the single read port of the
// byte ring memory, sign- or zero-extended and presented on the output.
// While searching, each byte takes two sum reads, the write, six sync and check reads and the
// compare; the next byte waits for that compare, and input is held off while fields are sent.
// Reset: synchronous active low; clears control state, pointer, sum and both byte counts.
module nav_frame_sync_and_field_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [5:0]       o_field_index,
    output logic [63:0]      o_field_value,
    output logic             o_last_field
);

    localparam int FRAME_LEN = nfsd_pkg::FrameLen;
    localparam int AW = $clog2(FRAME_LEN);

    // The window lives in a ring memory. The newest byte sits at r_wp-1,
    // so window position p is at address (r_wp + p) mod FRAME_LEN.
    // The ring is not cleared at reset. A fill count tells which window
    // positions were written since reset; the others count as zero in the sum.
    logic [7:0] r_mem [FRAME_LEN];
    logic [7:0] r_rd;

    typedef enum logic [2:0] {
        S_IDLE, S_SYNC, S_WAIT, S_CHK, S_FLD, S_OUT
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_wp;
    logic [7:0]      r_fresh;
    logic [7:0]      r_fill;
    logic [15:0]     r_sum;
    logic [15:0]     r_check;
    logic            r_sync_ok;
    logic [3:0]      r_step;   // read step within a phase
    logic [5:0]      r_fidx;
    logic [63:0]     r_acc;
    logic [7:0]      r_old2;

    logic [AW-1:0]   rd_addr;
    logic            rd_en;
    logic [8:0]      pos;
    nfsd_pkg::t_field_desc desc;

    assign desc = nfsd_pkg::field_desc(r_fidx);

    // Window position to ring address; pos < 2*FRAME_LEN.
    function automatic logic [AW-1:0] wrap(input logic [8:0] p);
        logic [9:0] s;
        s = 10'(p) + 10'(r_wp);
        if (s >= 10'(2 * FRAME_LEN)) s = s - 10'(2 * FRAME_LEN);
        if (s >= 10'(FRAME_LEN)) s = s - 10'(FRAME_LEN);
        return s[AW-1:0];
    endfunction

    // Read sequencing. S_IDLE reads positions 2 and 135 for the sum update
    // before the new byte lands. S_SYNC steps 0..5 read positions 0, 1, 2, 3,
    // 135 and 136 of the updated window for the sync and check compare.
    always_comb begin
        pos = 9'd0;
        rd_en = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_en = 1'b1;
                pos = (r_step == 4'd0) ? 9'(nfsd_pkg::SumFirst) : 9'(nfsd_pkg::CheckPos);
            end
            S_SYNC: begin
                rd_en = 1'b1;
                case (r_step)
                    4'd0: pos = 9'd0;
                    4'd1: pos = 9'd1;
                    4'd2: pos = 9'd2;
                    4'd3: pos = 9'd3;
                    4'd4: pos = 9'(nfsd_pkg::CheckPos);
                    default: pos = 9'(nfsd_pkg::CheckPos + 1);
                endcase
            end
            S_FLD: begin
                rd_en = 1'b1;
                pos = 9'(desc.offset) + 9'(r_step);
            end
            default: ;
        endcase
        rd_addr = wrap(pos);
    end

    logic do_write;
    assign o_ready  = (r_state == S_IDLE) && (r_step == 4'd2);
    assign do_write = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (do_write) r_mem[r_wp] <= i_rx_byte;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    logic [63:0] ext;
    always_comb begin
        ext = r_acc;
        case (desc.size)
            4'd1: ext = {{56{desc.is_signed & r_acc[7]}},  r_acc[7:0]};
            4'd2: ext = {{48{desc.is_signed & r_acc[15]}}, r_acc[15:0]};
            4'd4: ext = {{32{desc.is_signed & r_acc[31]}}, r_acc[31:0]};
            default: ext = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_fresh   <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_step    <= '0;
            r_fidx    <= '0;
            r_sync_ok <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // step0 read pos2, step1 read pos135 (old2 arrives), step2 wait byte
                    if (r_step == 4'd1) begin
                        r_old2 <= r_rd;
                        r_step <= 4'd2;
                    end else if (r_step == 4'd2) begin
                        if (do_write) begin
                            // Position p holds a written byte once the fill count
                            // reaches FRAME_LEN - p; unwritten bytes count as zero.
                            r_sum <= r_sum
                                - ((r_fill >= 8'(FRAME_LEN - nfsd_pkg::SumFirst)) ?
                                   16'(r_old2) : 16'd0)
                                + ((r_fill >= 8'(FRAME_LEN - nfsd_pkg::CheckPos)) ?
                                   16'(r_rd) : 16'd0);
                            r_wp <= (r_wp == AW'(FRAME_LEN - 1)) ? '0 : r_wp + 1'b1;
                            if (r_fresh < 8'(FRAME_LEN)) r_fresh <= r_fresh + 1'b1;
                            if (r_fill < 8'(FRAME_LEN)) r_fill <= r_fill + 1'b1;
                            r_step <= '0;
                            r_state <= S_SYNC;
                            r_sync_ok <= 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SYNC: begin
                    // data for step k-1 arrives at step k
                    case (r_step)
                        4'd1: if (r_rd != nfsd_pkg::Sync0) r_sync_ok <= 1'b0;
                        4'd2: if (r_rd != nfsd_pkg::Sync1) r_sync_ok <= 1'b0;
                        4'd3: if (r_rd != nfsd_pkg::Sync2) r_sync_ok <= 1'b0;
                        4'd4: if (r_rd != nfsd_pkg::Sync3) r_sync_ok <= 1'b0;
                        4'd5: r_check[7:0] <= r_rd;
                        default: ;
                    endcase
                    if (r_step == 4'd5) r_state <= S_WAIT;
                    r_step <= r_step + 1'b1;
                end
                S_WAIT: begin
                    r_check[15:8] <= r_rd;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_step <= '0;
                    r_fidx <= '0;
                    r_acc  <= '0;
                    if (r_sync_ok && r_fresh == 8'(FRAME_LEN) && r_check == r_sum) begin
                        r_state <= S_FLD;
                        r_fresh <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FLD: begin
                    // r_step issues reads; byte k arrives in the cycle after its read
                    if (r_step != 4'd0) begin
                        r_acc <= r_acc | (64'(r_rd) << (8 * (r_step - 4'd1)));
                    end
                    if (r_step == desc.size) begin
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid       <= 1'b1;
                        o_field_index <= r_fidx;
                        o_field_value <= ext;
                        o_last_field  <= (r_fidx == 6'(nfsd_pkg::FieldCount - 1));
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_step  <= '0;
                        r_acc   <= '0;
                        if (r_fidx == 6'(nfsd_pkg::FieldCount - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_fidx  <= r_fidx + 1'b1;
                            r_state <= S_FLD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_field_value))
        else $error("result dropped while stalled");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken during field output");
    a_fresh_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= 8'(FRAME_LEN))
        else $error("fresh count overflow");
    a_fresh_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= r_fill)
        else $error("fresh count ahead of fill count");

endmodule
`default_nettype wire
